### hdl/dpid_pkg.sv
// shared constants and types for the discrete pid difference-equation block
// no dependencies; referenced by dpid_fwd, dpid_fb and the top level
`default_nettype none

package dpid_pkg;

  localparam int DataWidthDef = 32;
  localparam int FracBitsDef  = 16;

  localparam int NumRegs  = 8;
  localparam int CfgAddrW = $clog2(NumRegs);

  typedef enum logic [CfgAddrW-1:0] {
    REG_SETPOINT     = 3'd0,
    REG_COEF_E_NOW   = 3'd1,
    REG_COEF_E_PREV  = 3'd2,
    REG_COEF_E_PREV2 = 3'd3,
    REG_COEF_U_PREV  = 3'd4,
    REG_COEF_U_PREV2 = 3'd5,
    REG_UPPER_LIMIT  = 3'd6,
    REG_LOWER_LIMIT  = 3'd7
  } cfg_reg_e;

endpackage

`default_nettype wire

### hdl/dpid_fwd.sv
// feed-forward path: input register, saturated error, error history,
// error-term products and their partial sum; uses dpid_pkg for defaults
`default_nettype none

module dpid_fwd #(
  parameter int DATA_WIDTH = dpid_pkg::DataWidthDef,
  parameter int FRAC_BITS  = dpid_pkg::FracBitsDef
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic signed [DATA_WIDTH-1:0]               setpoint_i,
  input  wire logic signed [DATA_WIDTH-1:0]               coef_e0_i,
  input  wire logic signed [DATA_WIDTH-1:0]               coef_e1_i,
  input  wire logic signed [DATA_WIDTH-1:0]               coef_e2_i,
  input  wire logic                                       in_valid_i,
  output logic                                            in_ready_o,
  input  wire logic signed [DATA_WIDTH-1:0]               measured_i,
  output logic                                            out_valid_o,
  input  wire logic                                       out_ready_i,
  output logic signed [2*DATA_WIDTH-FRAC_BITS+1:0]        psum_o
);

  localparam int W     = DATA_WIDTH;
  localparam int ProdW = 2*DATA_WIDTH - FRAC_BITS;
  localparam int SumW  = ProdW + 2;

  localparam logic signed [W-1:0] MaxVal = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MinVal = {1'b1, {(W-1){1'b0}}};

  // stage valids
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1: input register
  logic signed [W-1:0] meas_q;

  // stage 2: error and the two history values that go with it
  logic signed [W-1:0] err_q, ep1_q, ep2_q;
  logic signed [W-1:0] eh0_q, eh1_q;
  logic signed [W:0]   diff;
  logic signed [W-1:0] err_d;

  // stage 3: truncated products
  logic signed [2*W-1:0]   p0_full, p1_full, p2_full;
  logic signed [ProdW-1:0] p0_q, p1_q, p2_q;

  // stage 4: partial sum of the error terms
  logic signed [SumW-1:0] sum_d, sum_q;

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_ready_o  = rdy1;
  assign out_valid_o = v4_q;
  assign psum_o      = sum_q;

  always_comb begin
    diff = {setpoint_i[W-1], setpoint_i} - {meas_q[W-1], meas_q};
    if (diff[W] != diff[W-1]) begin
      err_d = diff[W] ? MinVal : MaxVal;
    end else begin
      err_d = diff[W-1:0];
    end
  end

  assign p0_full = coef_e0_i * err_q;
  assign p1_full = coef_e1_i * ep1_q;
  assign p2_full = coef_e2_i * ep2_q;

  assign sum_d = SumW'(p0_q) + SumW'(p1_q) + SumW'(p2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      eh0_q <= '0;
      eh1_q <= '0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
      // history advances once per transaction, in order
      if (v1_q && rdy2) begin
        eh0_q <= err_d;
        eh1_q <= eh0_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy1) begin
      meas_q <= measured_i;
    end
    if (v1_q && rdy2) begin
      err_q <= err_d;
      ep1_q <= eh0_q;
      ep2_q <= eh1_q;
    end
    if (v2_q && rdy3) begin
      p0_q <= p0_full[2*W-1:FRAC_BITS];
      p1_q <= p1_full[2*W-1:FRAC_BITS];
      p2_q <= p2_full[2*W-1:FRAC_BITS];
    end
    if (v3_q && rdy4) begin
      sum_q <= sum_d;
    end
  end

`ifndef SYNTH
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !out_ready_i |=> v4_q && $stable(sum_q))
    else $error("partial sum changed while stalled");

  a_hist_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && rdy2 |=> eh1_q == $past(eh0_q) && eh0_q == err_q)
    else $error("error history did not shift with the transaction");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> in_ready_o)
    else $error("input stage empty but not ready");
`endif

endmodule

`default_nettype wire

### hdl/dpid_fb.sv
// feedback stage: output-term products, saturation, clamps, output history
// and the result register; uses dpid_pkg for defaults
`default_nettype none

module dpid_fb #(
  parameter int DATA_WIDTH = dpid_pkg::DataWidthDef,
  parameter int FRAC_BITS  = dpid_pkg::FracBitsDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic signed [DATA_WIDTH-1:0]        coef_u1_i,
  input  wire logic signed [DATA_WIDTH-1:0]        coef_u2_i,
  input  wire logic signed [DATA_WIDTH-1:0]        upper_limit_i,
  input  wire logic signed [DATA_WIDTH-1:0]        lower_limit_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [2*DATA_WIDTH-FRAC_BITS+1:0] psum_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [DATA_WIDTH-1:0]             drive_o,
  output logic                                     clamped_o
);

  localparam int W     = DATA_WIDTH;
  localparam int ProdW = 2*DATA_WIDTH - FRAC_BITS;
  localparam int AccW  = ProdW + 3;

  localparam logic signed [W-1:0] MaxVal = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MinVal = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0]   u1_q, u2_q;
  logic signed [W-1:0]   drive_q;
  logic                  clamped_q;
  logic                  ov_q;
  logic                  load;

  logic signed [2*W-1:0] q1_full, q2_full;
  logic signed [AccW-1:0] acc;
  logic [AccW-W:0]       acc_top;
  logic signed [W-1:0]   sat_d, u_d;
  logic                  clamped_d;

  assign in_ready_o  = !ov_q || out_ready_i;
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign drive_o     = drive_q;
  assign clamped_o   = clamped_q;

  assign q1_full = coef_u1_i * u1_q;
  assign q2_full = coef_u2_i * u2_q;

  always_comb begin
    acc = AccW'(psum_i)
        + AccW'($signed(q1_full[2*W-1:FRAC_BITS]))
        + AccW'($signed(q2_full[2*W-1:FRAC_BITS]));
    acc_top = acc[AccW-1:W-1];
    // in range when everything above the result sign matches it
    if ((&acc_top) || !(|acc_top)) begin
      sat_d = acc[W-1:0];
    end else begin
      sat_d = acc[AccW-1] ? MinVal : MaxVal;
    end
    // lower clamp applied last so it wins when limits cross
    u_d = sat_d;
    if (u_d > upper_limit_i) begin
      u_d = upper_limit_i;
    end
    if (u_d < lower_limit_i) begin
      u_d = lower_limit_i;
    end
    clamped_d = (u_d != sat_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      u1_q <= '0;
      u2_q <= '0;
    end else begin
      if (in_ready_o) begin
        ov_q <= in_valid_i;
      end
      if (load) begin
        u1_q <= u_d;
        u2_q <= u1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      drive_q   <= u_d;
      clamped_q <= clamped_d;
    end
  end

`ifndef SYNTH
  a_hist_matches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> u1_q == drive_q)
    else $error("output history differs from pending result");

  a_hist_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> u2_q == $past(u1_q))
    else $error("output history did not shift");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> ov_q)
    else $error("loaded transaction not presented");
`endif

endmodule

`default_nettype wire

### hdl/discrete_pid_difference_equation.sv
// top level of the discrete pid difference-equation block: configuration
// registers plus dpid_fwd and dpid_fb; uses dpid_pkg
//
//   channel  | signals                                   | direction
//   input    | in_valid_i, in_ready_o, measured_i        | in
//   result   | out_valid_o, out_ready_i, drive_o, clamped_o | out
//   config   | cfg_we_i, cfg_addr_i, cfg_wdata_i         | in, write only
//
// one transaction per cycle sustained while out_ready_i is high; each input passes
// through the input reg, error, products, partial sum and output reg in that order.
// the cycle time is set by the output stage: two products on the output
// history, the final add, saturation and both clamps in one loop.
// stalls hold each stage in place; bubbles ahead of a stall still fill.
// reset (async, active low) clears valids, histories and config; limits go to full range.
`default_nettype none

module discrete_pid_difference_equation #(
  parameter int DATA_WIDTH = dpid_pkg::DataWidthDef,
  parameter int FRAC_BITS  = dpid_pkg::FracBitsDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [DATA_WIDTH-1:0]      measured_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [DATA_WIDTH-1:0]           drive_o,
  output logic                                   clamped_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [dpid_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  wire logic [DATA_WIDTH-1:0]             cfg_wdata_i
);

  localparam int W    = DATA_WIDTH;
  localparam int SumW = 2*DATA_WIDTH - FRAC_BITS + 2;

  localparam logic signed [W-1:0] MaxVal = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MinVal = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0] setpoint_q;
  logic signed [W-1:0] coef_e0_q, coef_e1_q, coef_e2_q;
  logic signed [W-1:0] coef_u1_q, coef_u2_q;
  logic signed [W-1:0] upper_limit_q, lower_limit_q;

  logic                  mid_valid, mid_ready;
  logic signed [SumW-1:0] mid_psum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q    <= '0;
      coef_e0_q     <= '0;
      coef_e1_q     <= '0;
      coef_e2_q     <= '0;
      coef_u1_q     <= '0;
      coef_u2_q     <= '0;
      upper_limit_q <= MaxVal;
      lower_limit_q <= MinVal;
    end else if (cfg_we_i) begin
      case (dpid_pkg::cfg_reg_e'(cfg_addr_i))
        dpid_pkg::REG_SETPOINT:     setpoint_q    <= cfg_wdata_i;
        dpid_pkg::REG_COEF_E_NOW:   coef_e0_q     <= cfg_wdata_i;
        dpid_pkg::REG_COEF_E_PREV:  coef_e1_q     <= cfg_wdata_i;
        dpid_pkg::REG_COEF_E_PREV2: coef_e2_q     <= cfg_wdata_i;
        dpid_pkg::REG_COEF_U_PREV:  coef_u1_q     <= cfg_wdata_i;
        dpid_pkg::REG_COEF_U_PREV2: coef_u2_q     <= cfg_wdata_i;
        dpid_pkg::REG_UPPER_LIMIT:  upper_limit_q <= cfg_wdata_i;
        dpid_pkg::REG_LOWER_LIMIT:  lower_limit_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  dpid_fwd #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_fwd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .setpoint_i  (setpoint_q),
    .coef_e0_i   (coef_e0_q),
    .coef_e1_i   (coef_e1_q),
    .coef_e2_i   (coef_e2_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .measured_i  (measured_i),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .psum_o      (mid_psum)
  );

  dpid_fb #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_fb (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .coef_u1_i     (coef_u1_q),
    .coef_u2_i     (coef_u2_q),
    .upper_limit_i (upper_limit_q),
    .lower_limit_i (lower_limit_q),
    .in_valid_i    (mid_valid),
    .in_ready_o    (mid_ready),
    .psum_i        (mid_psum),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .drive_o       (drive_o),
    .clamped_o     (clamped_o)
  );

endmodule

`default_nettype wire
